[sv/skct_pkg.sv]
// Shared types and constants for the sorted key count table.
`timescale 1ns / 1ps
package skct_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 16;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [OCC_W-1:0]      OCC_FULL  = OCC_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_FULL        = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SHDN_RD,
    S_SHDN_WR,
    S_LIST_RD,
    S_LIST_EMIT,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // One result item offered by the sequencer to the output register
  typedef struct packed {
    logic                  valid;
    status_t               status;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } res_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic             idle;
    logic [OCC_W-1:0] occ;
  } seq_stat_t;

endpackage

[sv/skct_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module skct_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid the next cycle and held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/skct_seq.sv]
// Sequencer: search, insert, delete and list over the entry memory.
`timescale 1ns / 1ps
module skct_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_accept,
  input  skct_pkg::op_t                 in_op,
  input  logic [skct_pkg::KEY_BITS-1:0] in_key,
  output skct_pkg::seq_stat_t           stat,
  output skct_pkg::res_t                res,
  input  logic                          res_ready
);
  import skct_pkg::*;

  seq_state_t            state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [OCC_W-1:0]      idx_r, idx_nxt;
  logic [OCC_W-1:0]      pos_r, pos_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  status_t               rst_r, rst_nxt;
  logic [KEY_BITS-1:0]   rkey_r, rkey_nxt;
  logic [COUNT_BITS-1:0] rcnt_r, rcnt_nxt;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;

  logic [OCC_W-1:0] idx_inc, idx_dec;
  logic             miss;
  logic [OCC_W-1:0] miss_pos;

  assign idx_inc = idx_r + OCC_W'(1);
  assign idx_dec = idx_r - OCC_W'(1);

  skct_ram #(
    .DEPTH  (DEPTH),
    .DATA_W ($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    rst_r  <= rst_nxt;
    rkey_r <= rkey_nxt;
    rcnt_r <= rcnt_nxt;
  end

  // Next state, memory accesses and result
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    occ_nxt   = occ_r;
    rst_nxt   = rst_r;
    rkey_nxt  = rkey_r;
    rcnt_nxt  = rcnt_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[IDX_W-1:0];
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_r[IDX_W-1:0];
    miss      = 1'b0;
    miss_pos  = idx_r;
    res       = '0;
    res.status = rst_r;
    res.key    = rkey_r;
    res.count  = rcnt_r;
    res.last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt   = in_op;
          key_nxt  = in_key;
          rkey_nxt = in_key;
          idx_nxt  = '0;
          unique case (in_op)
            OP_ADD, OP_REMOVE: state_nxt = S_SRCH_RD;
            OP_LIST: begin
              if (occ_r == '0) begin
                rst_nxt   = ST_NOT_PRESENT;
                rkey_nxt  = '0;
                rcnt_nxt  = '0;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_LIST_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Read the next candidate, or stop at the end of the table
      S_SRCH_RD: begin
        if (idx_r == occ_r) begin
          miss = 1'b1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_SRCH_CHK;
        end
      end

      S_SRCH_CHK: begin
        if (mem_rdata.key == key_r) begin
          mem_waddr     = idx_r[IDX_W-1:0];
          mem_wdata.key = key_r;
          if (op_r == OP_ADD) begin
            mem_we          = 1'b1;
            mem_wdata.count = (mem_rdata.count == COUNT_MAX) ? mem_rdata.count
                                                             : mem_rdata.count + COUNT_BITS'(1);
            rst_nxt   = ST_OK;
            rcnt_nxt  = mem_wdata.count;
            state_nxt = S_EMIT;
          end else if (mem_rdata.count > COUNT_BITS'(1)) begin
            mem_we          = 1'b1;
            mem_wdata.count = mem_rdata.count - COUNT_BITS'(1);
            rst_nxt   = ST_OK;
            rcnt_nxt  = mem_wdata.count;
            state_nxt = S_EMIT;
          end else begin
            // Last one removed: close the gap
            rst_nxt   = ST_OK;
            rcnt_nxt  = '0;
            state_nxt = S_SHDN_RD;
          end
        end else if (mem_rdata.key > key_r) begin
          miss = 1'b1;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH_RD;
        end
      end

      // Move entries up one place, from the top down to the insert point
      S_SHUP_RD: begin
        if (idx_r == pos_r) begin
          mem_we          = 1'b1;
          mem_wdata.key   = key_r;
          mem_wdata.count = COUNT_BITS'(1);
          occ_nxt   = occ_r + OCC_W'(1);
          rst_nxt   = ST_OK;
          rcnt_nxt  = COUNT_BITS'(1);
          state_nxt = S_EMIT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[IDX_W-1:0];
          state_nxt = S_SHUP_WR;
        end
      end

      S_SHUP_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = S_SHUP_RD;
      end

      // Move entries down one place over the deleted one
      S_SHDN_RD: begin
        if (idx_inc == occ_r) begin
          occ_nxt   = occ_r - OCC_W'(1);
          state_nxt = S_EMIT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IDX_W-1:0];
          state_nxt = S_SHDN_WR;
        end
      end

      S_SHDN_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_SHDN_RD;
      end

      S_LIST_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_LIST_EMIT;
      end

      // Offer one listed entry, hold it until the output takes it
      S_LIST_EMIT: begin
        res.valid  = 1'b1;
        res.status = ST_OK;
        res.key    = mem_rdata.key;
        res.count  = mem_rdata.count;
        res.last   = (idx_inc == occ_r);
        if (res_ready) begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == occ_r) ? S_IDLE : S_LIST_RD;
        end
      end

      S_EMIT: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Key not found: insert, report full, or report not present
    if (miss) begin
      rkey_nxt = key_r;
      rcnt_nxt = '0;
      if (op_r == OP_REMOVE) begin
        rst_nxt   = ST_NOT_PRESENT;
        state_nxt = S_EMIT;
      end else if (occ_r == OCC_FULL) begin
        rst_nxt   = ST_FULL;
        state_nxt = S_EMIT;
      end else begin
        pos_nxt   = miss_pos;
        idx_nxt   = occ_r;
        state_nxt = S_SHUP_RD;
      end
    end
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.occ  = occ_r;

endmodule

[sv/sorted_key_count_table_core.sv]
// Sorted key count table: top level with handshake and output register.
//
// Use: keeps up to DEPTH distinct keys in ascending order, each with a count.
// Input channel (in_valid/in_stall, in_op, in_key): add a key, remove one of
// a key, or list all entries; op 3 is dropped without a result.
// Result channel (out_valid/out_stall): status, key_out, count_out, last.
// Add and remove give one result; a list gives one result per entry with
// last on the highest key, or one not-present result for an empty table.
// Timing: one item is worked at a time; in_stall is high until the item's
// last result has entered the output register. The search reads one entry
// at a time from the entry memory (one read port, registered read data) and
// checks it; an insert or delete moves one entry at a time by a read and a
// write, so an add or remove takes longer the more entries it searches and
// moves. A list reads and then offers each entry in turn.
// The output register holds a result while out_stall is high and the
// sequencer waits on it. Reset empties the table at once; memory contents
// are not cleared, since entries beyond the occupancy are never read.
`timescale 1ns / 1ps
module sorted_key_count_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_op,
  input  logic [skct_pkg::KEY_BITS-1:0]   in_key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [skct_pkg::KEY_BITS-1:0]   out_key_out,
  output logic [skct_pkg::COUNT_BITS-1:0] out_count_out,
  output logic                            out_last
);
  import skct_pkg::*;

  seq_stat_t stat;
  res_t      res;
  logic      res_ready;
  logic      in_accept;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [KEY_BITS-1:0]   out_key_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic                  out_last_r;

  assign in_stall  = !stat.idle;
  assign in_accept = in_valid && stat.idle;
  assign res_ready = !out_valid_r || !out_stall;

  skct_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_op     (op_t'(in_op)),
    .in_key    (in_key),
    .stat      (stat),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output valid: load on a new result, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_status_r <= res.status;
      out_key_r    <= res.key;
      out_count_r  <= res.count;
      out_last_r   <= res.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key_out   = out_key_r;
  assign out_count_out = out_count_r;
  assign out_last      = out_last_r;

  // Occupancy stays within the table
  assert property (@(posedge clk) disable iff (!rst_n) stat.occ <= OCC_FULL)
    else $error("occupancy beyond table depth");

  // Occupancy moves by at most one per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (stat.occ != $past(stat.occ)) |->
      ((stat.occ == $past(stat.occ) + OCC_W'(1)) ||
       (stat.occ + OCC_W'(1) == $past(stat.occ))))
    else $error("occupancy jumped");

  // A full status is only reported on a full table
  assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status == ST_FULL) |-> (stat.occ == OCC_FULL))
    else $error("full status on a table with room");

  // No new item is taken while a result is still being offered
  assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_stall)
    else $error("item taken during result offer");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the sorted key count table core.
`timescale 1ns / 1ps
module testbench;
  import skct_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLDOFF_LEN  = 400;
  localparam int SETTLE       = 4 * DEPTH + 16;
  localparam int REPEAT_ADDS  = 3;
  localparam logic [KEY_BITS-1:0] REPEAT_KEY = 16'h8000;
  localparam int POOL_SIZE    = 20;
  localparam int RANDOM_ITEMS = 436;

  typedef struct {
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
  } table_cmd_t;

  typedef struct {
    status_t               status;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } table_result_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_op     = OP_NOP;
  logic [KEY_BITS-1:0]   in_key    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic [KEY_BITS-1:0]   out_key_out;
  logic [COUNT_BITS-1:0] out_count_out;
  logic                  out_last;

  // Commands waiting to be offered, and results the table must still produce
  table_cmd_t    cmd_queue[$];
  table_result_t pending_results[$];

  // Shadow copy of the table contents
  logic [KEY_BITS-1:0]   shadow_keys   [DEPTH];
  logic [COUNT_BITS-1:0] shadow_counts [DEPTH];
  int                    shadow_occ = 0;

  int error_count     = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int full_replies    = 0;
  int absent_replies  = 0;
  int saturated_adds  = 0;
  int holdoff_at      = 0;

  sorted_key_count_table_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_key_out  (out_key_out),
    .out_count_out(out_count_out),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void push_result(status_t st, logic [KEY_BITS-1:0] k,
                                      logic [COUNT_BITS-1:0] c, logic fin);
    table_result_t r;
    r.status = st;
    r.key    = k;
    r.count  = c;
    r.last   = fin;
    pending_results.push_back(r);
    if (st == ST_FULL) full_replies++;
    if (st == ST_NOT_PRESENT) absent_replies++;
  endfunction

  // Apply one command to the shadow table and queue the results it causes
  function automatic void table_apply(logic [1:0] op_bits, logic [KEY_BITS-1:0] key);
    op_t op;
    int  pos;
    bit  hit;
    op = op_t'(op_bits);
    pos = 0;
    while (pos < shadow_occ && shadow_keys[pos] < key) pos++;
    hit = (pos < shadow_occ) && (shadow_keys[pos] == key);
    case (op)
      OP_LIST: begin
        if (shadow_occ == 0) begin
          push_result(ST_NOT_PRESENT, '0, '0, 1'b1);
        end else begin
          for (int j = 0; j < shadow_occ; j++)
            push_result(ST_OK, shadow_keys[j], shadow_counts[j], j == shadow_occ - 1);
        end
      end
      OP_ADD: begin
        if (hit) begin
          if (shadow_counts[pos] < COUNT_MAX) shadow_counts[pos]++;
          else saturated_adds++;
          push_result(ST_OK, key, shadow_counts[pos], 1'b1);
        end else if (shadow_occ >= DEPTH) begin
          push_result(ST_FULL, key, '0, 1'b1);
        end else begin
          // Open a slot at the sorted position
          for (int j = shadow_occ; j > pos; j--) begin
            shadow_keys[j]   = shadow_keys[j-1];
            shadow_counts[j] = shadow_counts[j-1];
          end
          shadow_keys[pos]   = key;
          shadow_counts[pos] = COUNT_BITS'(1);
          shadow_occ++;
          push_result(ST_OK, key, COUNT_BITS'(1), 1'b1);
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          push_result(ST_NOT_PRESENT, key, '0, 1'b1);
        end else if (shadow_counts[pos] > 1) begin
          shadow_counts[pos]--;
          push_result(ST_OK, key, shadow_counts[pos], 1'b1);
        end else begin
          // Close the gap left by the deleted entry
          for (int j = pos; j + 1 < shadow_occ; j++) begin
            shadow_keys[j]   = shadow_keys[j+1];
            shadow_counts[j] = shadow_counts[j+1];
          end
          shadow_occ--;
          push_result(ST_OK, key, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(op_t op, logic [KEY_BITS-1:0] key);
    table_cmd_t c;
    c.op  = op;
    c.key = key;
    cmd_queue.push_back(c);
  endfunction

  // Driver: offer queued commands in bursts, hold the item while stalled
  int burst_left = 1;
  int gap_left   = 0;
  always @(posedge clk) begin
    table_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        table_apply(in_op, in_key);
        items_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          c = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_op    <= c.op;
          in_key   <= c.key;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random stretches of light, heavy or no stalling, plus one long hold-off
  int  stall_mode    = 0;
  int  stretch_left  = 0;
  int  holdoff_left  = 0;
  bit  holdoff_done  = 1'b0;
  always @(posedge clk) begin
    logic nxt;
    nxt = 1'b0;
    if (rst_n) begin
      if (holdoff_left > 0) begin
        holdoff_left--;
        nxt = 1'b1;
      end else if (!holdoff_done && holdoff_at > 0 && items_accepted >= holdoff_at) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN - 1;
        nxt = 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stall_mode   = $urandom_range(0, 2);
          stretch_left = $urandom_range(10, 80);
        end
        stretch_left--;
        case (stall_mode)
          1:       nxt = ($urandom_range(0, 3) == 0);
          2:       nxt = ($urandom_range(0, 9) < 6);
          default: nxt = 1'b0;
        endcase
      end
    end
    out_stall <= nxt;
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    table_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d key %h count %0d last %0d",
               out_status, out_key_out, out_count_out, out_last);
        error_count++;
      end else begin
        r = pending_results.pop_front();
        results_checked++;
        if (out_status !== r.status) begin
          $error("status mismatch: expected %0d, actual %0d", r.status, out_status);
          error_count++;
        end
        if (out_key_out !== r.key) begin
          $error("key_out mismatch: expected %h, actual %h", r.key, out_key_out);
          error_count++;
        end
        if (out_count_out !== r.count) begin
          $error("count_out mismatch: expected %0d, actual %0d", r.count, out_count_out);
          error_count++;
        end
        if (out_last !== r.last) begin
          $error("last mismatch: expected %0d, actual %0d", r.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    logic [KEY_BITS-1:0] k;
    int                  pick;
    bit                  add_heavy;
    op_t                 op;

    // Empty-table cases and insert/delete at both ends
    queue_cmd(OP_LIST,   16'h0000);
    queue_cmd(OP_REMOVE, 16'h1234);
    queue_cmd(OP_NOP,    16'hABCD);
    queue_cmd(OP_ADD,    16'hFFFF);
    queue_cmd(OP_ADD,    16'h0000);
    queue_cmd(OP_REMOVE, 16'h0000);
    queue_cmd(OP_REMOVE, 16'hFFFF);

    // Add one key several times while the table is small, then take one back
    for (int i = 0; i < REPEAT_ADDS; i++) queue_cmd(OP_ADD, REPEAT_KEY);
    queue_cmd(OP_REMOVE, REPEAT_KEY);

    // Fill the table, then add a missing key when full and list everything
    queue_cmd(OP_ADD, 16'h0000);
    queue_cmd(OP_ADD, 16'hFFFF);
    for (int i = 1; i <= 14; i++)
      if (i != 8) queue_cmd(OP_ADD, KEY_BITS'(i * 16'h1111));
    queue_cmd(OP_ADD,  16'h0001);
    queue_cmd(OP_LIST, 16'h5555);

    // Random part: alternate remove-heavy and add-heavy stretches over a key pool
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_BITS'($urandom);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_heavy = ((i / 40) % 2) == 1;
      pick = $urandom_range(0, 99);
      if (pick < (add_heavy ? 60 : 20))  op = OP_ADD;
      else if (pick < 85)                op = OP_REMOVE;
      else if (pick < 97)                op = OP_LIST;
      else                               op = OP_NOP;
      if ($urandom_range(0, 9) == 0) k = KEY_BITS'($urandom);
      else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      queue_cmd(op, k);
    end
    holdoff_at = cmd_queue.size() - 250;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all commands taken and all results seen, then let the block settle
    while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    $display("run covered %0d commands and checked %0d results", items_accepted,
             results_checked);
    $display("including %0d saturated adds, %0d full and %0d not-present replies",
             saturated_adds, full_replies, absent_replies);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
sv/skct_pkg.sv
sv/skct_ram.sv
sv/skct_seq.sv
sv/sorted_key_count_table_core.sv
tb/testbench.sv
